FILE: hdl/assert_macros.svh
// Assertion macros used by the checker module of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the antecedent implies the consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Checks that the antecedent implies the consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: hdl/rlead_pkg.sv
// Types and constants of the run-length encoder.
package rlead_pkg;

    // Longest run that one count digit can describe.
    localparam logic [3:0] RUN_LIMIT = 4'd9;

    // ASCII code of the digit zero.
    localparam logic [7:0] DIGIT_BASE = 8'h30;

    // Number of result slots in the output queue.
    localparam int QUEUE_DEPTH = 6;

    // Most results that one item can cause.
    localparam int MAX_RESULTS = 4;

    // One result item as it waits in the output queue.
    typedef struct packed {
        logic [7:0] data;
        logic       burst;
        logic       stream;
    } rlead_item_t;

endpackage

FILE: hdl/run_length_encoder_ascii_digit_top.sv
// Run-length encoder: takes one byte per item and emits count digit and run byte pairs.
//
// Each input item updates the held run in the cycle it is accepted and queues the
// zero, two or four result bytes it causes into a six-slot output queue; the output
// port sends one byte per cycle while out_ready is high. An item that only extends or
// starts a run queues no bytes, an item that flushes one pair queues two, and a final
// byte that also breaks a run queues four.
// The single-byte output port is the bottleneck. Input is taken whenever two or fewer
// results are queued, so the next item waits only while three or more results are
// still queued. Runs are at most nine bytes long, so each count digit is one of
// '1' to '9'; after a final byte the encoder starts over for the next text.
module run_length_encoder_ascii_digit_top
    import rlead_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       final_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       burst_end,
    output logic       stream_end
);

    logic [7:0]  run_byte_reg;
    logic [7:0]  run_byte_next;
    logic [3:0]  run_length_reg;
    logic [3:0]  run_length_next;
    logic [2:0]  count_reg;
    logic [2:0]  count_next;
    rlead_item_t slot_reg  [QUEUE_DEPTH];
    rlead_item_t slot_next [QUEUE_DEPTH];

    logic        accept;
    logic        pop;
    logic        flush;
    logic        fresh;
    logic [3:0]  new_length;
    logic [7:0]  new_byte;
    logic [2:0]  num_results;
    logic [2:0]  base;
    rlead_item_t result [MAX_RESULTS];

    // Handshakes: input is taken while at most two results are queued.
    assign in_ready  = (count_reg <= 3'd2);
    assign accept    = in_valid && in_ready;
    assign out_valid = (count_reg != 3'd0);
    assign pop       = out_valid && out_ready;

    assign out_byte   = slot_reg[0].data;
    assign burst_end  = slot_reg[0].burst;
    assign stream_end = slot_reg[0].stream;

    // Run decisions for the incoming byte.
    assign flush = (run_length_reg != 4'd0)
                   && ((data_byte != run_byte_reg) || (run_length_reg >= RUN_LIMIT));
    assign fresh = flush || (run_length_reg == 4'd0);
    assign new_length = fresh ? 4'd1 : run_length_reg + 4'd1;
    assign new_byte   = fresh ? data_byte : run_byte_reg;
    assign num_results = {flush & final_byte, flush ^ final_byte, 1'b0};

    // Results in order: the broken run's pair first, then the final pair.
    always_comb
    begin
        result[0] = '{data: DIGIT_BASE + {4'd0, run_length_reg}, burst: 1'b0, stream: 1'b0};
        result[1] = '{data: run_byte_reg, burst: !final_byte, stream: 1'b0};
        result[2] = '{data: DIGIT_BASE + {4'd0, new_length}, burst: 1'b0, stream: 1'b0};
        result[3] = '{data: new_byte, burst: 1'b1, stream: 1'b1};
        if (!flush)
        begin
            result[0] = result[2];
            result[1] = result[3];
        end
    end

    // Next run state: the final byte returns the encoder to its reset state.
    always_comb
    begin
        run_byte_next   = run_byte_reg;
        run_length_next = run_length_reg;
        if (accept)
        begin
            if (final_byte)
            begin
                run_byte_next   = 8'd0;
                run_length_next = 4'd0;
            end
            else
            begin
                run_byte_next   = new_byte;
                run_length_next = new_length;
            end
        end
    end

    // Output queue: shift out the sent result, then append the new results.
    always_comb
    begin
        logic [2:0] idx;
        idx  = 3'd0;
        base = count_reg - {2'd0, pop};
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            slot_next[i] = slot_reg[i];
            if (pop && (i < QUEUE_DEPTH - 1))
            begin
                slot_next[i] = slot_reg[(i + 1) % QUEUE_DEPTH];
            end
        end
        if (accept)
        begin
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                idx = 3'(i) - base;
                if ((3'(i) >= base) && (idx < num_results))
                begin
                    slot_next[i] = result[idx[1:0]];
                end
            end
        end
        count_next = base + (accept ? num_results : 3'd0);
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_byte_reg   <= 8'd0;
            run_length_reg <= 4'd0;
            count_reg      <= 3'd0;
        end
        else
        begin
            run_byte_reg   <= run_byte_next;
            run_length_reg <= run_length_next;
            count_reg      <= count_next;
        end
    end

    // Queue payload.
    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

endmodule

FILE: hdl/rlead_checker.sv
// Port-level checker of the run-length encoder, bound to its top level.
`include "assert_macros.svh"

module rlead_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [7:0] data_byte,
    input logic       final_byte,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       burst_end,
    input logic       stream_end
);

    // The end of the stream always closes the burst of its item.
    `ASSERT_IMPLIES(a_stream_closes_burst, clk, rst_n, out_valid && stream_end, burst_end)

    // A stalled result stays valid with its byte and stream flag unchanged.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
                 out_valid && $stable(out_byte) && $stable(stream_end))

    // A final byte always flushes a pair, so a result is waiting in the next cycle.
    `ASSERT_NEXT(a_final_flushes, clk, rst_n, in_valid && in_ready && final_byte, out_valid)

endmodule

bind run_length_encoder_ascii_digit_top rlead_checker u_rlead_checker (.*);

FILE: dv/tb_run_length_encoder_ascii_digit_top.sv
// Self-checking testbench for the run-length encoder with ASCII count digits.
`timescale 1ns / 100ps

// Predicts the count-digit and run-byte pairs of the encoder and checks the emitted bytes.
class rle_pair_scoreboard;

    logic [7:0]                held_byte;
    logic [3:0]                held_len;
    rlead_pkg::rlead_item_t    pending_bytes [$];
    int                        mismatches;

    function new();
        held_byte   = 8'h00;
        held_len    = 4'd0;
        mismatches  = 0;
    endfunction

    // Prints one mismatch line and counts it.
    task report_mismatch(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    function void queue_byte(input logic [7:0] data, input logic burst, input logic stream);
        rlead_pkg::rlead_item_t entry;
        entry.data   = data;
        entry.burst  = burst;
        entry.stream = stream;
        pending_bytes.push_back(entry);
    endfunction

    // Advances the held run by one accepted byte and queues the pairs it flushes.
    function void absorb_byte(input logic [7:0] data, input logic last);
        if (held_len != 4'd0 && (data != held_byte || held_len >= rlead_pkg::RUN_LIMIT))
        begin
            queue_byte(rlead_pkg::DIGIT_BASE + {4'd0, held_len}, 1'b0, 1'b0);
            queue_byte(held_byte, !last, 1'b0);
            held_byte = data;
            held_len  = 4'd1;
        end
        else if (held_len == 4'd0)
        begin
            held_byte = data;
            held_len  = 4'd1;
        end
        else
        begin
            held_len = held_len + 4'd1;
        end

        // The final byte flushes whatever run is left and ends the text.
        if (last)
        begin
            queue_byte(rlead_pkg::DIGIT_BASE + {4'd0, held_len}, 1'b0, 1'b0);
            queue_byte(held_byte, 1'b1, 1'b1);
            held_byte = 8'h00;
            held_len  = 4'd0;
        end
    endfunction

    // Compares one emitted byte with the oldest predicted one.
    task check_emitted(input logic [7:0] data, input logic burst, input logic stream);
        rlead_pkg::rlead_item_t want;
        if (pending_bytes.size() == 0)
        begin
            report_mismatch($sformatf("unexpected byte %h burst %b stream %b",
                                      data, burst, stream));
        end
        else
        begin
            want = pending_bytes.pop_front();
            if (data !== want.data)
                report_mismatch($sformatf("out_byte %h, predicted %h", data, want.data));
            if (burst !== want.burst)
                report_mismatch($sformatf("burst_end %b, predicted %b (byte %h)",
                                          burst, want.burst, want.data));
            if (stream !== want.stream)
                report_mismatch($sformatf("stream_end %b, predicted %b (byte %h)",
                                          stream, want.stream, want.data));
        end
    endtask

    function int outstanding();
        return pending_bytes.size();
    endfunction

endclass

module tb_run_length_encoder_ascii_digit_top;

    import rlead_pkg::*;

    localparam int STALL_LIMIT     = 2000;
    localparam int ITEMS_PER_PHASE = 78;
    localparam int DRAIN_CYCLES    = 16;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] data_byte;
    logic       final_byte;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] out_byte;
    logic       burst_end;
    logic       stream_end;

    int send_idle_pct;
    int recv_stall_pct;
    int quiet_cycles;
    int send_idle_by_phase  [4] = '{0, 81, 0, 19};
    int recv_stall_by_phase [4] = '{0, 0, 81, 19};

    rle_pair_scoreboard sb = new();

    run_length_encoder_ascii_digit_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .burst_end  (burst_end),
        .stream_end (stream_end)
    );

    // 100 MHz clock.
    always #5 clk = ~clk;

    // The receiver stalls at random according to the current phase.
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Handshake monitor: predicts on accepted input, checks accepted output,
    // and ends the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.absorb_byte(data_byte, final_byte);
            if (out_valid && out_ready)
                sb.check_emitted(out_byte, burst_end, stream_end);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Presents one byte after a random idle gap and waits until it is taken.
    task automatic send_item(input logic [7:0] data, input logic last);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= data;
        final_byte <= last;
        do @(posedge clk); while (!in_ready);
    endtask

    // Sends one text ending in a final byte: mostly runs over a small alphabet,
    // sometimes plain random bytes.
    task automatic send_random_text(ref int sent);
        int         n_runs;
        int         run_len;
        logic [7:0] run_val;
        logic [7:0] letters [3];
        if ($urandom_range(99) < 15)
        begin
            run_len = $urandom_range(1, 8);
            for (int j = 0; j < run_len; j++)
                send_item(8'($urandom_range(0, 255)), j == run_len - 1);
            sent += run_len;
        end
        else
        begin
            foreach (letters[k])
                letters[k] = 8'($urandom_range(0, 255));
            n_runs = $urandom_range(1, 5);
            for (int r = 0; r < n_runs; r++)
            begin
                run_val = letters[$urandom_range(0, 2)];
                run_len = ($urandom_range(99) < 20) ? $urandom_range(9, 19)
                                                    : $urandom_range(1, 8);
                for (int j = 0; j < run_len; j++)
                    send_item(run_val, (r == n_runs - 1) && (j == run_len - 1));
                sent += run_len;
            end
        end
    endtask

    initial
    begin
        int sent;
        clk            = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        data_byte      = 8'h00;
        final_byte     = 1'b0;
        out_ready      = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        quiet_cycles   = 0;

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: a one-byte text with all bits set.
        send_item(8'hFF, 1'b1);
        // A run broken by the final byte, which flushes two pairs at once.
        send_item(8'h01, 1'b0);
        send_item(8'h01, 1'b0);
        send_item(8'h02, 1'b1);
        // Ten equal bytes: the full run of nine is flushed by an equal byte.
        for (int j = 0; j < 10; j++)
            send_item(8'h41, j == 9);
        // Zero bytes form runs like any other value.
        send_item(8'h00, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h55, 1'b0);
        send_item(8'hAA, 1'b1);
        // Neighboring values across the top bit.
        send_item(8'h80, 1'b0);
        send_item(8'h7F, 1'b1);

        // Random texts under each idling pattern.
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = send_idle_by_phase[p];
            recv_stall_pct = recv_stall_by_phase[p];
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
                send_random_text(sent);
        end

        @(negedge clk);
        in_valid <= 1'b0;

        // Drain; the watchdog catches a result that never comes.
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.outstanding() != 0)
            sb.report_mismatch($sformatf("%0d predicted bytes never emitted",
                                         sb.outstanding()));

        if (sb.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
